// File: sv/lvd_pkg.sv
// Shared types, widths and codes for the log-domain Viterbi decoder.
package lvd_pkg;

   localparam int DATA_W   = 32;
   localparam int OP_W     = 2;
   localparam int CFG_W    = 5;
   localparam int TIME_W   = 6;
   localparam int PSTATE_W = 4;
   localparam int STATUS_W = 2;

   localparam int DEF_MAX_STATES = 16;
   localparam int DEF_MAX_STEPS  = 64;

   localparam logic [CFG_W-1:0] CFG_NUM_STATES_RESET = 5'd2;

   // Q16.16 limits; the most negative code is minus infinity
   localparam logic signed [DATA_W-1:0] NEG_INF = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] POS_MAX = 32'sh7FFF_FFFF;

   localparam logic [OP_W-1:0] OP_INIT   = 2'd0;
   localparam logic [OP_W-1:0] OP_TRANS  = 2'd1;
   localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_TR_CMP,
      ST_TR_WRITE,
      ST_AM_READ,
      ST_AM_CMP,
      ST_TB_EMIT,
      ST_TB_READ,
      ST_FIN_EMPTY
   } state_type;

endpackage

// File: sv/lvd_sat_add.sv
// Shared Q16.16 saturating adder with minus-infinity propagation.
module lvd_sat_add (
   input  logic signed [lvd_pkg::DATA_W-1:0] a,
   input  logic signed [lvd_pkg::DATA_W-1:0] b,
   output logic signed [lvd_pkg::DATA_W-1:0] sum
);
   import lvd_pkg::*;

   localparam logic signed [DATA_W:0] WIDE_MAX = 33'sd2147483647;
   localparam logic signed [DATA_W:0] WIDE_MIN = -33'sd2147483647;

   logic signed [DATA_W:0] wide;

   assign wide = {a[DATA_W-1], a} + {b[DATA_W-1], b};

   always_comb begin
      if ((a == NEG_INF) || (b == NEG_INF)) begin
         sum = NEG_INF;
      end else if (wide > WIDE_MAX) begin
         sum = POS_MAX;
      end else if (wide < WIDE_MIN) begin
         sum = WIDE_MIN[DATA_W-1:0];
      end else begin
         sum = wide[DATA_W-1:0];
      end
   end

endmodule

// File: sv/lvd_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle.
module lvd_ram #(
   parameter int WIDTH = 32,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [2**AW];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// File: sv/log_viterbi_time_varying_decoder.sv
// Top level of the log-domain Viterbi decoder for time-varying HMMs.
//
// Usage: a transaction is taken on req_* when start is high and busy low.
// Operation init loads one state of the first score column per transaction;
// operation trans carries one source candidate A(src,dst,t) plus the
// destination's emission, destination outer and source inner; operation
// finish runs the argmax and the traceback.
// Steps: init passes through the init state; trans passes through a compare
// state, plus a write state on the last source of a destination (score and
// back-pointer write). Finish with a loaded sequence runs the argmax over the
// score RAM (N states in use), a read and a compare state per state, then the
// traceback, an emit and a read state per time step, as each back-pointer
// comes out of a registered RAM read; no new transaction is taken until idle.
// Results appear on rsp_* for exactly one cycle, marked by rsp_strobe; the
// receiver cannot stall, so no backpressure exists. rsp_last marks time 0.
// csr_num_states is always ready and is to be written only while idle.
// Reset clears the sequence counters and sets num_states to 2; score and
// back-pointer RAMs are not cleared and hold nothing until written.
module log_viterbi_time_varying_decoder #(
   parameter int MAX_STATES = lvd_pkg::DEF_MAX_STATES,
   parameter int MAX_STEPS  = lvd_pkg::DEF_MAX_STEPS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [lvd_pkg::OP_W-1:0]            req_operation,
   input  logic signed [lvd_pkg::DATA_W-1:0]   req_log_value,
   input  logic signed [lvd_pkg::DATA_W-1:0]   req_log_emission,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lvd_pkg::CFG_W-1:0]           csr_num_states,
   output logic                                rsp_strobe,
   output logic [lvd_pkg::TIME_W-1:0]          rsp_time_index,
   output logic [lvd_pkg::PSTATE_W-1:0]        rsp_path_state,
   output logic signed [lvd_pkg::DATA_W-1:0]   rsp_best_score,
   output logic [lvd_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                rsp_last
);
   import lvd_pkg::*;

   localparam int SW    = $clog2(MAX_STATES);    // state index
   localparam int STW   = $clog2(MAX_STEPS + 1); // column count, holds MAX_STEPS
   localparam int TIW   = $clog2(MAX_STEPS);     // time index
   localparam int SC_AW = SW + 1;                // two score banks
   localparam int BP_AW = TIW + SW;

   // control state
   state_type            state_ff, state_in;
   logic [CFG_W-1:0]     ns_cfg_ff, ns_cfg_in;
   logic [STW-1:0]       step_ff, step_in;
   logic [SW-1:0]        src_ff, src_in;
   logic [SW-1:0]        dest_ff, dest_in;
   logic signed [DATA_W-1:0] rb_ff, rb_in;   // running best, also argmax best
   logic [SW-1:0]        rbs_ff, rbs_in;     // best source, also traceback state
   logic                 dropped_ff, dropped_in;
   logic                 bank_ff, bank_in;   // score bank holding previous column
   logic                 rsp_strobe_ff, rsp_strobe_in;

   // payload registers
   logic signed [DATA_W-1:0] val_ff, val_in;
   logic signed [DATA_W-1:0] emis_ff, emis_in;
   logic [TIME_W-1:0]        rsp_time_ff, rsp_time_in;
   logic [PSTATE_W-1:0]      rsp_path_ff, rsp_path_in;
   logic signed [DATA_W-1:0] rsp_best_ff, rsp_best_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                 accept;
   logic [SW-1:0]        last_idx;
   logic                 src_last, dest_last;
   logic [STW-1:0]       ti;

   logic signed [DATA_W-1:0] add_a, add_b, add_sum;

   logic                 sc_we;
   logic [SC_AW-1:0]     sc_waddr, sc_raddr;
   logic [DATA_W-1:0]    sc_rdata;
   logic signed [DATA_W-1:0] sc_rd;

   logic                 bp_we;
   logic [BP_AW-1:0]     bp_waddr, bp_raddr;
   logic [SW-1:0]        bp_rdata;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // last index in use: 0 acts as 1 state, large values clamp to MAX_STATES
   always_comb begin
      if (ns_cfg_ff == '0) begin
         last_idx = '0;
      end else if (int'(ns_cfg_ff) >= MAX_STATES) begin
         last_idx = SW'(MAX_STATES - 1);
      end else begin
         last_idx = SW'(ns_cfg_ff - CFG_W'(1));
      end
   end

   assign src_last  = (src_ff >= last_idx);
   assign dest_last = (dest_ff >= last_idx);
   assign ti        = step_ff - STW'(1);
   assign sc_rd     = sc_rdata;

   // one adder serves init sums, candidates and the emission add
   always_comb begin
      case (state_ff)
         ST_TR_CMP: begin
            add_a = sc_rd;
            add_b = val_ff;
         end
         ST_TR_WRITE: begin
            add_a = rb_ff;
            add_b = emis_ff;
         end
         default: begin
            add_a = val_ff;
            add_b = emis_ff;
         end
      endcase
   end

   lvd_sat_add u_add (
      .a   (add_a),
      .b   (add_b),
      .sum (add_sum)
   );

   // score columns: bank_ff holds the previous column, the other the next
   lvd_ram #(.WIDTH(DATA_W), .AW(SC_AW)) u_score_ram (
      .clock (clock),
      .we    (sc_we),
      .waddr (sc_waddr),
      .wdata (add_sum),
      .raddr (sc_raddr),
      .rdata (sc_rdata)
   );

   // back-pointers, addressed by time step and destination
   lvd_ram #(.WIDTH(SW), .AW(BP_AW)) u_bp_ram (
      .clock (clock),
      .we    (bp_we),
      .waddr (bp_waddr),
      .wdata (rbs_ff),
      .raddr (bp_raddr),
      .rdata (bp_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_operation)
                  OP_INIT: begin
                     state_in = (step_ff == '0) ? ST_INIT : ST_IDLE;
                  end
                  OP_TRANS: begin
                     if ((step_ff != '0) && (step_ff < STW'(MAX_STEPS))) begin
                        state_in = ST_TR_CMP;
                     end
                  end
                  OP_FINISH: begin
                     state_in = (step_ff == '0) ? ST_FIN_EMPTY : ST_AM_READ;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_INIT:      state_in = ST_IDLE;
         ST_TR_CMP:    state_in = src_last ? ST_TR_WRITE : ST_IDLE;
         ST_TR_WRITE:  state_in = ST_IDLE;
         ST_AM_READ:   state_in = ST_AM_CMP;
         ST_AM_CMP:    state_in = src_last ? ST_TB_EMIT : ST_AM_READ;
         ST_TB_EMIT:   state_in = (step_ff == STW'(1)) ? ST_IDLE : ST_TB_READ;
         ST_TB_READ:   state_in = ST_TB_EMIT;
         ST_FIN_EMPTY: state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // memory controls
   always_comb begin
      sc_we    = (state_ff == ST_INIT) || (state_ff == ST_TR_WRITE);
      sc_waddr = {(state_ff == ST_TR_WRITE) ? ~bank_ff : bank_ff, dest_ff};
      sc_raddr = {bank_ff, src_ff};
      bp_we    = (state_ff == ST_TR_WRITE);
      bp_waddr = {TIW'(step_ff), dest_ff};
      bp_raddr = {TIW'(ti), rbs_ff};
   end

   // datapath and counters
   always_comb begin
      ns_cfg_in     = ns_cfg_ff;
      step_in       = step_ff;
      src_in        = src_ff;
      dest_in       = dest_ff;
      rb_in         = rb_ff;
      rbs_in        = rbs_ff;
      dropped_in    = dropped_ff;
      bank_in       = bank_ff;
      rsp_strobe_in = 1'b0;
      val_in        = val_ff;
      emis_in       = emis_ff;
      rsp_time_in   = rsp_time_ff;
      rsp_path_in   = rsp_path_ff;
      rsp_best_in   = rsp_best_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_valid && csr_ready) begin
         ns_cfg_in = csr_num_states;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               val_in  = req_log_value;
               emis_in = req_log_emission;
               if ((req_operation == OP_TRANS) && (step_ff != '0) &&
                   (step_ff >= STW'(MAX_STEPS))) begin
                  dropped_in = 1'b1;
               end
               if ((req_operation == OP_FINISH) && (step_ff != '0)) begin
                  src_in = '0;  // argmax sweep index; partial step is dropped
               end
            end
         end
         ST_INIT: begin
            if (dest_last) begin
               dest_in = '0;
               step_in = STW'(1);
            end else begin
               dest_in = dest_ff + SW'(1);
            end
         end
         ST_TR_CMP: begin
            // first source always wins; later ones only if strictly better
            if ((src_ff == '0) || (add_sum > rb_ff)) begin
               rb_in  = add_sum;
               rbs_in = src_ff;
            end
            if (!src_last) begin
               src_in = src_ff + SW'(1);
            end
         end
         ST_TR_WRITE: begin
            src_in = '0;
            rb_in  = NEG_INF;
            rbs_in = '0;
            if (dest_last) begin
               dest_in = '0;
               bank_in = ~bank_ff;
               step_in = step_ff + STW'(1);
            end else begin
               dest_in = dest_ff + SW'(1);
            end
         end
         ST_AM_CMP: begin
            if ((src_ff == '0) || (sc_rd > rb_ff)) begin
               rb_in  = sc_rd;
               rbs_in = src_ff;
            end
            if (!src_last) begin
               src_in = src_ff + SW'(1);
            end
         end
         ST_TB_EMIT: begin
            rsp_strobe_in = 1'b1;
            rsp_time_in   = TIME_W'(ti);
            rsp_path_in   = PSTATE_W'(rbs_ff);
            rsp_best_in   = rb_ff;
            rsp_status_in = dropped_ff ? STATUS_DROPPED : STATUS_OK;
            rsp_last_in   = (ti == '0);
            if (ti == '0) begin
               step_in    = '0;
               src_in     = '0;
               dest_in    = '0;
               rb_in      = NEG_INF;
               rbs_in     = '0;
               dropped_in = 1'b0;
            end else begin
               step_in = ti;
            end
         end
         ST_TB_READ: begin
            rbs_in = bp_rdata;
         end
         ST_FIN_EMPTY: begin
            rsp_strobe_in = 1'b1;
            rsp_time_in   = '0;
            rsp_path_in   = '0;
            rsp_best_in   = NEG_INF;
            rsp_status_in = STATUS_EMPTY;
            rsp_last_in   = 1'b1;
            step_in       = '0;
            src_in        = '0;
            dest_in       = '0;
            rb_in         = NEG_INF;
            rbs_in        = '0;
            dropped_in    = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ns_cfg_ff     <= CFG_NUM_STATES_RESET;
         step_ff       <= '0;
         src_ff        <= '0;
         dest_ff       <= '0;
         rb_ff         <= NEG_INF;
         rbs_ff        <= '0;
         dropped_ff    <= 1'b0;
         bank_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ns_cfg_ff     <= ns_cfg_in;
         step_ff       <= step_in;
         src_ff        <= src_in;
         dest_ff       <= dest_in;
         rb_ff         <= rb_in;
         rbs_ff        <= rbs_in;
         dropped_ff    <= dropped_in;
         bank_ff       <= bank_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff        <= val_in;
      emis_ff       <= emis_in;
      rsp_time_ff   <= rsp_time_in;
      rsp_path_ff   <= rsp_path_in;
      rsp_best_ff   <= rsp_best_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_time_index = rsp_time_ff;
   assign rsp_path_state = rsp_path_ff;
   assign rsp_best_score = rsp_best_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_last       = rsp_last_ff;

`ifndef SYNTHESIS
   // a result only follows a traceback emit or an empty finish
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |->
         ($past(state_ff) == ST_TB_EMIT || $past(state_ff) == ST_FIN_EMPTY))
      else $error("result strobe without emit state");

   // the final result leaves the sequence cleared and the block idle
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_last_ff) |-> (state_ff == ST_IDLE && step_ff == '0))
      else $error("sequence not cleared after last result");

   // column count never passes capacity
   a_step_cap: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STW'(MAX_STEPS))
      else $error("step counter beyond capacity");

   // a transition transaction past capacity raises the drop flag
   a_drop_flag: assert property (@(posedge clock) disable iff (reset)
      (accept && req_operation == OP_TRANS && step_ff >= STW'(MAX_STEPS))
         |=> dropped_ff)
      else $error("dropped step not flagged");
`endif

endmodule

// File: bench/testbench.sv
// Self-checking bench for the log-domain time-varying Viterbi decoder.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import lvd_pkg::*;

   // Op 3 is not decoded by the block; it must be swallowed without effect
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam logic signed [DATA_W-1:0] SAT_LOW = 32'sh8000_0001;
   localparam logic signed [DATA_W-1:0] Q_ONE   = 32'sh0001_0000;

   localparam int CYCLE_LIMIT  = 400000;
   // Worst case tail: argmax over 16 states plus a 64-step traceback
   localparam int TAIL_CYCLES  = 2 * DEF_MAX_STATES + 2 * DEF_MAX_STEPS + 40;
   // Idle margin before a register write
   localparam int SETTLE       = 4;
   localparam int RANDOM_ITEMS = 200;

   typedef struct packed {
      logic [TIME_W-1:0]          time_index;
      logic [PSTATE_W-1:0]        path_state;
      logic signed [DATA_W-1:0]   best_score;
      logic [STATUS_W-1:0]        status;
      logic                       last;
   } path_entry_type;

   typedef struct {
      logic [OP_W-1:0]            op;
      logic signed [DATA_W-1:0]   val;
      logic signed [DATA_W-1:0]   emis;
   } req_item_type;

   // ------------------------------------------------------------------
   // DUT hookup; every input has a known value from time zero
   // ------------------------------------------------------------------
   logic                       clock            = 1'b0;
   logic                       reset            = 1'b1;
   logic                       start            = 1'b0;
   logic                       busy;
   logic [OP_W-1:0]            req_operation    = OP_INIT;
   logic signed [DATA_W-1:0]   req_log_value    = '0;
   logic signed [DATA_W-1:0]   req_log_emission = '0;
   logic                       csr_valid        = 1'b0;
   logic                       csr_ready;
   logic [CFG_W-1:0]           csr_num_states   = CFG_NUM_STATES_RESET;
   logic                       rsp_strobe;
   logic [TIME_W-1:0]          rsp_time_index;
   logic [PSTATE_W-1:0]        rsp_path_state;
   logic signed [DATA_W-1:0]   rsp_best_score;
   logic [STATUS_W-1:0]        rsp_status;
   logic                       rsp_last;

   log_viterbi_time_varying_decoder i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_log_value    (req_log_value),
      .req_log_emission (req_log_emission),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_num_states   (csr_num_states),
      .rsp_strobe       (rsp_strobe),
      .rsp_time_index   (rsp_time_index),
      .rsp_path_state   (rsp_path_state),
      .rsp_best_score   (rsp_best_score),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Decoder prediction: own copy of the sequence state and register
   // ------------------------------------------------------------------
   logic [CFG_W-1:0]           cfg_num_states = CFG_NUM_STATES_RESET;
   logic signed [DATA_W-1:0]   sc_prev [DEF_MAX_STATES];
   logic signed [DATA_W-1:0]   sc_next [DEF_MAX_STATES];
   logic [PSTATE_W-1:0]        bp_mem  [DEF_MAX_STEPS][DEF_MAX_STATES];
   logic signed [DATA_W-1:0]   run_best = NEG_INF;
   int                         run_src  = 0;
   int                         src_cnt  = 0;
   int                         dest_cnt = 0;
   int                         step_cnt = 0;
   logic                       dropped  = 1'b0;

   path_entry_type             path_expected [$];

   int                         mismatches = 0;
   int                         items_sent = 0;
   int                         cycle_count = 0;
   bit                         no_idle = 1'b0;

   // Q16.16 add; minus infinity is absorbing, everything else saturates
   // one code above it
   function automatic logic signed [DATA_W-1:0] q_add(input logic signed [DATA_W-1:0] a,
                                                      input logic signed [DATA_W-1:0] b);
      logic signed [DATA_W:0] wide;
      if (a == NEG_INF || b == NEG_INF)
         return NEG_INF;
      wide = a + b;
      if (wide > 33'sd2147483647)
         return POS_MAX;
      if (wide < -33'sd2147483647)
         return SAT_LOW;
      return wide[DATA_W-1:0];
   endfunction

   // 0 behaves as 1, anything past the state capacity as the capacity
   function automatic int states_used();
      if (cfg_num_states == 0)
         return 1;
      if (cfg_num_states > DEF_MAX_STATES)
         return DEF_MAX_STATES;
      return int'(cfg_num_states);
   endfunction

   function automatic void clear_path_state();
      run_best = NEG_INF;
      run_src  = 0;
      src_cnt  = 0;
      dest_cnt = 0;
      step_cnt = 0;
      dropped  = 1'b0;
   endfunction

   // Advance the predicted state by one accepted transaction and queue
   // whatever path entries it produces
   function automatic void viterbi_update(input logic [OP_W-1:0] op,
                                          input logic signed [DATA_W-1:0] val,
                                          input logic signed [DATA_W-1:0] emis);
      int                         ns;
      int                         s;
      int                         t;
      int                         ti;
      int                         q;
      logic signed [DATA_W-1:0]   cand;
      logic signed [DATA_W-1:0]   best;
      path_entry_type             e;
      ns = states_used();
      case (op)
         OP_INIT: begin
            // only while the first column is still being loaded
            if (step_cnt == 0) begin
               if (dest_cnt < DEF_MAX_STATES)
                  sc_prev[dest_cnt] = q_add(val, emis);
               if (dest_cnt + 1 >= ns) begin
                  dest_cnt = 0;
                  step_cnt = 1;
               end else begin
                  dest_cnt++;
               end
            end
         end
         OP_TRANS: begin
            if (step_cnt != 0) begin
               if (step_cnt >= DEF_MAX_STEPS) begin
                  dropped = 1'b1;
               end else begin
                  cand = q_add(sc_prev[src_cnt], val);
                  // strict compare: first source keeps a tie
                  if (src_cnt == 0 || cand > run_best) begin
                     run_best = cand;
                     run_src  = src_cnt;
                  end
                  if (src_cnt + 1 >= ns) begin
                     bp_mem[step_cnt][dest_cnt] = run_src[PSTATE_W-1:0];
                     sc_next[dest_cnt] = q_add(run_best, emis);
                     src_cnt  = 0;
                     run_best = NEG_INF;
                     run_src  = 0;
                     if (dest_cnt + 1 >= ns) begin
                        dest_cnt = 0;
                        sc_prev  = sc_next;
                        step_cnt++;
                     end else begin
                        dest_cnt++;
                     end
                  end else begin
                     src_cnt++;
                  end
               end
            end
         end
         OP_FINISH: begin
            if (step_cnt == 0) begin
               e.time_index = '0;
               e.path_state = '0;
               e.best_score = NEG_INF;
               e.status     = STATUS_EMPTY;
               e.last       = 1'b1;
               path_expected.push_back(e);
            end else begin
               best = sc_prev[0];
               q    = 0;
               for (s = 1; s < ns; s++) begin
                  if (sc_prev[s] > best) begin
                     best = sc_prev[s];
                     q    = s;
                  end
               end
               for (t = step_cnt; t > 0; t--) begin
                  ti = t - 1;
                  e.time_index = ti[TIME_W-1:0];
                  e.path_state = q[PSTATE_W-1:0];
                  e.best_score = best;
                  e.status     = dropped ? STATUS_DROPPED : STATUS_OK;
                  e.last       = (ti == 0);
                  path_expected.push_back(e);
                  if (ti > 0)
                     q = bp_mem[ti][q];
               end
            end
            clear_path_state();
         end
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Mix of extremes, exact ties and ordinary log-probabilities
   function automatic logic signed [DATA_W-1:0] pick_q();
      logic signed [DATA_W-1:0] r;
      case ($urandom_range(0, 11))
         0:       r = NEG_INF;
         1:       r = POS_MAX;
         2:       r = SAT_LOW;
         3:       r = $urandom;
         4:       r = 32'sh0;
         5:       r = -Q_ONE;
         6:       r = -2 * Q_ONE;
         default: begin
            r = $urandom_range(0, 32'h000C_0000);
            r = r - 32'sh000A_0000;
         end
      endcase
      return r;
   endfunction

   // One transaction. start is left high after acceptance so that a
   // back-to-back item does not need a second assignment in the same step.
   task automatic send_item(input logic [OP_W-1:0] op,
                            input logic signed [DATA_W-1:0] val,
                            input logic signed [DATA_W-1:0] emis);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_operation    <= op;
      req_log_value    <= val;
      req_log_emission <= emis;
      do @(posedge clock); while (busy);
      viterbi_update(op, val, emis);
      if (op != OP_UNUSED)
         items_sent++;
   endtask

   task automatic end_burst();
      start <= 1'b0;
      @(posedge clock);
   endtask

   // Hold the sender until every queued path entry has come out
   task automatic wait_for_path();
      end_burst();
      while (path_expected.size() != 0)
         @(posedge clock);
   endtask

   // Register write, only at a sequence boundary with the block idle
   task automatic write_num_states(input logic [CFG_W-1:0] value);
      wait_for_path();
      repeat (SETTLE) @(posedge clock);
      while (busy)
         @(posedge clock);
      csr_valid      <= 1'b1;
      csr_num_states <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid      <= 1'b0;
      cfg_num_states  = value;
   endtask

   // Init column, `steps` transition columns, then finish. With cut >= 0
   // only the first `cut` items go out before the finish (broken sequence).
   task automatic send_sequence(input int steps, input int cut);
      req_item_type              items [$];
      req_item_type              it;
      logic signed [DATA_W-1:0]  emis;
      int                        ns;
      int                        n;
      int                        k;
      int                        d;
      int                        s;
      ns = states_used();
      for (d = 0; d < ns; d++) begin
         it.op   = OP_INIT;
         it.val  = pick_q();
         it.emis = pick_q();
         items.push_back(it);
      end
      for (k = 1; k < steps + 1; k++) begin
         for (d = 0; d < ns; d++) begin
            emis = pick_q();
            for (s = 0; s < ns; s++) begin
               it.op   = OP_TRANS;
               it.val  = pick_q();
               it.emis = emis;
               items.push_back(it);
            end
         end
      end
      n = (cut >= 0 && cut < items.size()) ? cut : items.size();
      for (k = 0; k < n; k++) begin
         // occasional undecoded op between good items
         if ($urandom_range(0, 19) == 0)
            send_item(OP_UNUSED, $urandom, $urandom);
         send_item(items[k].op, items[k].val, items[k].emis);
      end
      send_item(OP_FINISH, pick_q(), pick_q());
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset setting of two states: empty finish, ordering rules, undecoded
   // op, saturation both ways, minus-infinity candidates, partial step
   task automatic test_order_and_saturation();
      send_item(OP_FINISH, 32'sh0, 32'sh0);
      send_item(OP_UNUSED, POS_MAX, NEG_INF);
      send_item(OP_TRANS, Q_ONE, Q_ONE);              // before init: ignored
      send_item(OP_INIT, POS_MAX, POS_MAX);           // saturates high
      send_item(OP_INIT, NEG_INF, 32'sh0);            // minus infinity
      send_item(OP_INIT, 32'sh0, 32'sh0);             // column full: ignored
      send_item(OP_TRANS, 32'sh0, -Q_ONE);
      send_item(OP_TRANS, POS_MAX, -Q_ONE);
      send_item(OP_TRANS, SAT_LOW, 32'sh0);
      send_item(OP_TRANS, 32'sh0, 32'sh0);
      // all-minus-infinity candidates: source 0 must win
      send_item(OP_TRANS, NEG_INF, 32'sh7FFF_0000);
      send_item(OP_TRANS, NEG_INF, 32'sh7FFF_0000);
      send_item(OP_TRANS, -Q_ONE, NEG_INF);
      send_item(OP_TRANS, -Q_ONE, NEG_INF);
      send_item(OP_FINISH, NEG_INF, POS_MAX);
      // partial step is discarded at finish; low saturation on init
      send_item(OP_INIT, SAT_LOW, -Q_ONE);
      send_item(OP_INIT, -Q_ONE, SAT_LOW);
      send_item(OP_TRANS, $urandom, $urandom);
      send_item(OP_FINISH, $urandom, $urandom);
      // a half-loaded init column counts as no sequence
      send_item(OP_INIT, Q_ONE, Q_ONE);
      send_item(OP_FINISH, 32'sh0, 32'sh0);
   endtask

   // Register extremes: 0 acts as 1, 17 and 31 clamp to 16
   task automatic test_state_count_extremes();
      write_num_states(5'd0);
      send_sequence(3, -1);
      write_num_states(5'd1);
      send_sequence(2, -1);
      write_num_states(5'd17);
      send_sequence(0, -1);
      write_num_states(5'd16);
      send_sequence(0, -1);
      write_num_states(5'd31);
      send_sequence(0, -1);
   endtask

   // A full 64-column path, then one that overruns capacity
   task automatic test_capacity();
      write_num_states(5'd1);
      no_idle = 1'b1;
      send_sequence(DEF_MAX_STEPS - 1, -1);
      wait_for_path();
      no_idle = 1'b0;
      send_item(OP_INIT, pick_q(), pick_q());
      repeat (DEF_MAX_STEPS + 4)
         send_item(OP_TRANS, pick_q(), pick_q());
      send_item(OP_FINISH, 32'sh0, 32'sh0);
      wait_for_path();
   endtask

   // Mostly well-formed sequences with random content, some broken ones
   // and some noise; register rewritten between sequences
   task automatic test_random_sequences();
      int stop_at;
      int kind;
      int ns;
      int steps;
      stop_at = items_sent + RANDOM_ITEMS;
      write_num_states(5'd2);
      while (items_sent < stop_at) begin
         no_idle = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 9) == 0)
               write_num_states(CFG_W'($urandom_range(6, 9)));
            else
               write_num_states(CFG_W'($urandom_range(0, 5)));
         end else if ($urandom_range(0, 5) == 0) begin
            wait_for_path();
         end
         ns = states_used();
         if (ns >= 6)
            steps = 1;
         else if ($urandom_range(0, 4) == 0)
            steps = $urandom_range(7, 14);
         else
            steps = $urandom_range(1, 6);
         // keep the last sequence close to the remaining budget
         while (steps > 1 && ns + steps * ns * ns > stop_at - items_sent)
            steps--;
         kind = $urandom_range(0, 9);
         if (kind <= 6) begin
            send_sequence(steps, -1);
         end else if (kind == 7) begin
            send_sequence(steps, $urandom_range(0, ns + steps * ns * ns - 1));
         end else if (kind == 8) begin
            repeat ($urandom_range(1, 8))
               send_item(OP_W'($urandom_range(0, 3)), pick_q(), pick_q());
            send_item(OP_FINISH, pick_q(), pick_q());
         end else begin
            send_item(OP_FINISH, pick_q(), pick_q());
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Result checker: every strobe is one transaction out, no backpressure
   // ------------------------------------------------------------------
   path_entry_type got_entry;
   path_entry_type exp_entry;

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         got_entry.time_index = rsp_time_index;
         got_entry.path_state = rsp_path_state;
         got_entry.best_score = rsp_best_score;
         got_entry.status     = rsp_status;
         got_entry.last       = rsp_last;
         if (path_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: t=%0d state=%0d score=%0d status=%0d last=%0d",
                        got_entry.time_index, got_entry.path_state,
                        got_entry.best_score, got_entry.status, got_entry.last);
         end else begin
            exp_entry = path_expected.pop_front();
            if (got_entry.time_index !== exp_entry.time_index ||
                got_entry.path_state !== exp_entry.path_state ||
                got_entry.best_score !== exp_entry.best_score ||
                got_entry.status     !== exp_entry.status     ||
                got_entry.last       !== exp_entry.last) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: exp t=%0d state=%0d score=%0d status=%0d last=%0d",
                           exp_entry.time_index, exp_entry.path_state,
                           exp_entry.best_score, exp_entry.status, exp_entry.last);
                  $display("          got t=%0d state=%0d score=%0d status=%0d last=%0d",
                           got_entry.time_index, got_entry.path_state,
                           got_entry.best_score, got_entry.status, got_entry.last);
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   initial begin
      for (int i = 0; i < DEF_MAX_STATES; i++) begin
         sc_prev[i] = '0;
         sc_next[i] = '0;
      end
      for (int i = 0; i < DEF_MAX_STEPS; i++)
         for (int j = 0; j < DEF_MAX_STATES; j++)
            bp_mem[i][j] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_order_and_saturation();
      test_state_count_extremes();
      test_capacity();
      test_random_sequences();
      wait_for_path();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && path_expected.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
